>>> hw/rtl/fpr_pkg.sv
// Shared types, codes and CRC step for the framed packet receive checker.
`timescale 1ns / 1ps

package fpr_pkg;

    localparam int CNT_W = 12;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_VERDICT = 2'd1;
    localparam logic [1:0] KIND_ACK     = 2'd2;

    localparam logic [15:0] KNOCK_PATTERN = 16'h2A23;
    localparam logic [7:0]  ACK_SIZE_LO   = 8'h02;
    localparam logic [7:0]  ACK_SIZE_HI   = 8'h00;
    localparam logic [2:0]  ACK_LAST_IDX  = 3'd6;

    localparam logic CFG_START_MARKER = 1'b0;
    localparam logic CFG_ACK_TYPE     = 1'b1;

    typedef enum logic [3:0] {
        V_OK          = 4'd0,
        V_SHORT       = 4'd1,
        V_BADSTART    = 4'd2,
        V_KNOCK       = 4'd3,
        V_EMPTY       = 4'd4,
        V_LENMISMATCH = 4'd5,
        V_CRC         = 4'd6,
        V_SEQ         = 4'd7,
        V_OVERFLOW    = 4'd8
    } t_verdict;

    typedef struct packed {
        logic       has_data;
        logic [7:0] data;
        logic       is_last;
        t_verdict   verdict;
        logic [7:0] seq;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_HEAD,
        ST_VERD,
        ST_ACK
    } t_back_state;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] x;
        x = {crc[7:0], crc[15:8]} ^ {8'h00, d};
        x = x ^ {12'h000, x[7:4]};
        x = x ^ {x[3:0], 12'h000};
        x = x ^ {3'b000, x[7:0], 5'b00000};
        return x;
    endfunction

endpackage

>>> hw/rtl/framed_packet_receive_checker.sv
// Top level of the framed packet receive checker.
`timescale 1ns / 1ps

// Takes one received byte per cycle while the command queue is not full and returns, in
// order, the delayed payload bytes of the frame, one verdict at the end of each transaction
// and a seven-byte ACK frame after each accepted frame. The front end absorbs one byte per
// clock unless the queue is full: the byte-wise CRC-16, the counters and the verdict logic
// all settle within that cycle. Each input byte turns into at most one queued command, and
// the result sequencer emits one transaction per clock while popped, so a run of payload
// bytes streams at one byte per cycle; a frame's end adds a verdict, and seven ACK bytes
// after an accepted frame, which the four-entry command queue hides as long as the next
// frame's header bytes arrive. The ACK CRC is built one byte per cycle, when popped, as its
// leading bytes are sent. Transactions over MAX_TRANSACTION bytes get the overflow verdict.
module framed_packet_receive_checker
    import fpr_pkg::*;
#(
    parameter int MAX_TRANSACTION = 2048
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_transaction,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic [3:0] o_verdict,
    output logic       o_last_of_run
);

    logic [7:0] r_start_marker;
    logic [7:0] r_ack_type_code;
    logic       accept;
    logic       cmd_push;
    t_cmd       cmd_in;
    t_cmd       cmd_head;
    logic       cmd_pop;
    logic       cmd_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker  <= '0;
            r_ack_type_code <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_START_MARKER: r_start_marker  <= i_cfg_wdata;
                CFG_ACK_TYPE:     r_ack_type_code <= i_cfg_wdata;
                default:          r_start_marker  <= r_start_marker;
            endcase
        end
    end

    assign accept = push && !full;

    fpr_front #(
        .MAX_TRANSACTION(MAX_TRANSACTION)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (accept),
        .i_data_byte         (i_data_byte),
        .i_end_of_transaction(i_end_of_transaction),
        .i_start_marker      (r_start_marker),
        .o_cmd_push          (cmd_push),
        .o_cmd               (cmd_in)
    );

    fpr_cmd_fifo #(
        .DEPTH(4)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_push),
        .i_cmd  (cmd_in),
        .i_pop  (cmd_pop),
        .o_cmd  (cmd_head),
        .o_full (full),
        .o_empty(cmd_empty)
    );

    fpr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd_head),
        .i_cmd_empty    (cmd_empty),
        .o_cmd_pop      (cmd_pop),
        .i_start_marker (r_start_marker),
        .i_ack_type_code(r_ack_type_code),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_kind         (o_kind),
        .o_out_byte     (o_out_byte),
        .o_verdict      (o_verdict),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

>>> hw/rtl/fpr_front.sv
// Front end: tracks one transaction, forwards delayed payload and decides the verdict.
`timescale 1ns / 1ps

module fpr_front
    import fpr_pkg::*;
#(
    parameter int MAX_TRANSACTION = 2048
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_transaction,
    input  logic [7:0] i_start_marker,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TRANSACTION);

    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_seq, n_seq;
    logic [15:0]      r_size, n_size;
    logic             r_start_ok, n_start_ok;
    logic [15:0]      r_knock, n_knock;
    logic [7:0]       r_delay0, n_delay0;
    logic [7:0]       r_delay1, n_delay1;
    logic             r_overflow, n_overflow;
    logic             emit_data;
    t_verdict         verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_crc      <= '0;
            r_seq      <= '0;
            r_size     <= '0;
            r_start_ok <= 1'b0;
            r_knock    <= '0;
            r_delay0   <= '0;
            r_delay1   <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_seq      <= n_seq;
            r_size     <= n_size;
            r_start_ok <= n_start_ok;
            r_knock    <= n_knock;
            r_delay0   <= n_delay0;
            r_delay1   <= n_delay1;
            r_overflow <= n_overflow;
        end
    end

    always_comb begin
        n_count    = r_count;
        n_crc      = r_crc;
        n_seq      = r_seq;
        n_size     = r_size;
        n_start_ok = r_start_ok;
        n_knock    = r_knock;
        n_delay0   = r_delay0;
        n_delay1   = r_delay1;
        n_overflow = r_overflow;
        emit_data  = 1'b0;
        verdict    = V_OK;

        if (i_accept) begin
            if (!r_overflow && (r_count >= MAX_CNT)) begin
                n_overflow = 1'b1;
            end
            if (!n_overflow) begin
                if (r_count == '0) begin
                    n_start_ok = (i_data_byte == i_start_marker);
                end else begin
                    n_crc = crc_step(r_crc, i_data_byte);
                end
                if (r_count == CNT_W'(1)) begin
                    n_size[7:0] = i_data_byte;
                end else if (r_count == CNT_W'(2)) begin
                    n_size[15:8] = i_data_byte;
                end else if (r_count == CNT_W'(3)) begin
                    n_knock[15:8] = i_data_byte;
                end else if (r_count == CNT_W'(4)) begin
                    n_knock[7:0] = i_data_byte;
                end
                emit_data = (r_count >= CNT_W'(6));
                n_delay1  = r_delay0;
                n_delay0  = i_data_byte;
                n_count   = r_count + CNT_W'(1);
            end
        end

        priority if (n_overflow) begin
            verdict = V_OVERFLOW;
        end else if (n_count < CNT_W'(5)) begin
            verdict = V_SHORT;
        end else if (!n_start_ok) begin
            verdict = V_BADSTART;
        end else if (n_size == '0) begin
            verdict = (n_knock == KNOCK_PATTERN) ? V_KNOCK : V_EMPTY;
        end else if (({1'b0, n_size} + 17'd5) != {{(17-CNT_W){1'b0}}, n_count}) begin
            verdict = V_LENMISMATCH;
        end else if (n_crc != '0) begin
            verdict = V_CRC;
        end else if (n_knock[15:8] != r_seq) begin
            verdict = V_SEQ;
        end else begin
            verdict = V_OK;
        end

        if (i_accept && i_end_of_transaction) begin
            if (verdict == V_OK) begin
                n_seq = r_seq + 8'd1;
            end
            n_count    = '0;
            n_crc      = '0;
            n_size     = '0;
            n_start_ok = 1'b0;
            n_knock    = '0;
            n_delay0   = '0;
            n_delay1   = '0;
            n_overflow = 1'b0;
        end
    end

    assign o_cmd_push     = i_accept && (emit_data || i_end_of_transaction);
    assign o_cmd.has_data = emit_data;
    assign o_cmd.data     = r_delay1;
    assign o_cmd.is_last  = i_end_of_transaction;
    assign o_cmd.verdict  = verdict;
    assign o_cmd.seq      = r_seq;

    a_overflow_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (r_count == MAX_CNT))
        else $error("overflow flag set with count below the limit");

endmodule

>>> hw/rtl/fpr_cmd_fifo.sv
// Short command queue between the front end and the result sequencer.
`timescale 1ns / 1ps

module fpr_cmd_fifo
    import fpr_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W2 = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_cmd              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W2-1:0] r_fill;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_fill == CNT_W2'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + CNT_W2'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - CNT_W2'(1);
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command pushed into a full queue");

endmodule

>>> hw/rtl/fpr_back.sv
// Result sequencer: expands queued commands into payload, verdict and ACK transactions.
`timescale 1ns / 1ps

module fpr_back
    import fpr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_empty,
    output logic       o_cmd_pop,
    input  logic [7:0] i_start_marker,
    input  logic [7:0] i_ack_type_code,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic [3:0] o_verdict,
    output logic       o_last_of_run
);

    t_back_state r_state, n_state;
    logic [2:0]  r_ack_idx, n_ack_idx;
    logic [15:0] r_crc, n_crc;
    logic        r_valid, n_valid;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_byte, n_byte;
    logic [3:0]  r_verdict, n_verdict;
    logic        r_last, n_last;
    logic        advance;
    logic [7:0]  ack_byte;

    assign advance = !r_valid || i_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_HEAD;
            r_ack_idx <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ack_idx <= n_ack_idx;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc     <= n_crc;
        r_kind    <= n_kind;
        r_byte    <= n_byte;
        r_verdict <= n_verdict;
        r_last    <= n_last;
    end

    always_comb begin
        unique case (r_ack_idx)
            3'd0:    ack_byte = i_start_marker;
            3'd1:    ack_byte = ACK_SIZE_LO;
            3'd2:    ack_byte = ACK_SIZE_HI;
            3'd3:    ack_byte = i_cmd.seq;
            3'd4:    ack_byte = i_ack_type_code;
            3'd5:    ack_byte = r_crc[15:8];
            3'd6:    ack_byte = r_crc[7:0];
            default: ack_byte = '0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_ack_idx = r_ack_idx;
        n_crc     = r_crc;
        n_valid   = r_valid;
        n_kind    = r_kind;
        n_byte    = r_byte;
        n_verdict = r_verdict;
        n_last    = r_last;
        o_cmd_pop = 1'b0;

        if (advance) begin
            n_valid = 1'b0;
            unique case (r_state)
                ST_HEAD: begin
                    if (!i_cmd_empty) begin
                        n_valid = 1'b1;
                        if (i_cmd.has_data) begin
                            n_kind    = KIND_DATA;
                            n_byte    = i_cmd.data;
                            n_verdict = V_OK;
                            n_last    = !i_cmd.is_last;
                            if (i_cmd.is_last) begin
                                n_state = ST_VERD;
                            end else begin
                                o_cmd_pop = 1'b1;
                            end
                        end else begin
                            n_kind    = KIND_VERDICT;
                            n_byte    = '0;
                            n_verdict = i_cmd.verdict;
                            n_last    = (i_cmd.verdict != V_OK);
                            if (i_cmd.verdict == V_OK) begin
                                n_state   = ST_ACK;
                                n_ack_idx = '0;
                                n_crc     = '0;
                            end else begin
                                o_cmd_pop = 1'b1;
                            end
                        end
                    end
                end
                ST_VERD: begin
                    n_valid   = 1'b1;
                    n_kind    = KIND_VERDICT;
                    n_byte    = '0;
                    n_verdict = i_cmd.verdict;
                    n_last    = (i_cmd.verdict != V_OK);
                    if (i_cmd.verdict == V_OK) begin
                        n_state   = ST_ACK;
                        n_ack_idx = '0;
                        n_crc     = '0;
                    end else begin
                        n_state   = ST_HEAD;
                        o_cmd_pop = 1'b1;
                    end
                end
                ST_ACK: begin
                    n_valid   = 1'b1;
                    n_kind    = KIND_ACK;
                    n_byte    = ack_byte;
                    n_verdict = V_OK;
                    n_last    = (r_ack_idx == ACK_LAST_IDX);
                    if ((r_ack_idx != 3'd0) && (r_ack_idx < 3'd5)) begin
                        n_crc = crc_step(r_crc, ack_byte);
                    end
                    if (r_ack_idx == ACK_LAST_IDX) begin
                        n_state   = ST_HEAD;
                        n_ack_idx = '0;
                        o_cmd_pop = 1'b1;
                    end else begin
                        n_ack_idx = r_ack_idx + 3'd1;
                    end
                end
                default: begin
                    n_state = ST_HEAD;
                end
            endcase
        end
    end

    assign o_empty       = !r_valid;
    assign o_kind        = r_kind;
    assign o_out_byte    = r_byte;
    assign o_verdict     = r_verdict;
    assign o_last_of_run = r_last;

    a_cmd_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_HEAD) |-> !i_cmd_empty)
        else $error("sequencer mid-command with an empty queue");

    a_verdict_only_on_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_kind != KIND_VERDICT)) |-> (r_verdict == V_OK))
        else $error("verdict field set on a non-verdict transaction");

    a_fail_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_kind == KIND_VERDICT) && (r_verdict != V_OK)) |-> r_last)
        else $error("failing verdict not marked last");

endmodule

>>> tb/sv/fpr_tb_pkg.sv
// CRC-16/XModem helper shared by the frame builder and the result monitor.
`timescale 1ns / 1ps

package fpr_tb_pkg;

    function automatic logic [15:0] crc16_xmodem_next(input logic [15:0] crc,
                                                      input logic [7:0] d);
        logic [15:0] acc;
        int b;
        acc = crc ^ {d, 8'h00};
        for (b = 0; b < 8; b++) begin
            if (acc[15]) begin
                acc = {acc[14:0], 1'b0} ^ 16'h1021;
            end else begin
                acc = {acc[14:0], 1'b0};
            end
        end
        return acc;
    endfunction

endpackage

>>> tb/sv/fpr_frame_monitor.sv
// Watches the byte and result channels, predicts every result and compares.
`timescale 1ns / 1ps

module fpr_frame_monitor
    import fpr_pkg::*;
    import fpr_tb_pkg::*;
#(
    parameter int MAX_BYTES = 2048
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_transaction,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_out_byte,
    input  logic [3:0] i_verdict,
    input  logic       i_last_of_run,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        t_verdict   verdict;
        logic       run_end;
    } t_result;

    t_result     awaited_results [$];
    int          fail_count;

    logic [7:0]  marker_reg;
    logic [7:0]  ack_type_reg;
    logic [11:0] byte_count;
    logic [15:0] crc_accum;
    logic [7:0]  seq_number;
    logic [15:0] size_field;
    logic        start_ok;
    logic [15:0] knock_field;
    logic [7:0]  delay_line [0:1];
    logic        overflowed;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic clear_transaction();
        byte_count    = '0;
        crc_accum     = '0;
        size_field    = '0;
        start_ok      = 1'b0;
        knock_field   = '0;
        delay_line[0] = '0;
        delay_line[1] = '0;
        overflowed    = 1'b0;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic eot);
        t_result     res [0:8];
        int          n;
        int          k;
        logic [11:0] idx;
        t_verdict    v;
        logic [7:0]  ack [0:6];
        logic [15:0] c;
        n = 0;
        if (!overflowed && byte_count >= MAX_BYTES) begin
            overflowed = 1'b1;
        end
        if (!overflowed) begin
            idx = byte_count;
            if (idx == 12'd0) begin
                start_ok = (b == marker_reg);
            end else begin
                crc_accum = crc16_xmodem_next(crc_accum, b);
            end
            case (idx)
                12'd1: size_field[7:0] = b;
                12'd2: size_field[15:8] = b;
                12'd3: knock_field[15:8] = b;
                12'd4: knock_field[7:0] = b;
                default: ;
            endcase
            if (idx >= 12'd6) begin
                res[n] = '{KIND_DATA, delay_line[1], V_OK, 1'b0};
                n++;
            end
            delay_line[1] = delay_line[0];
            delay_line[0] = b;
            byte_count = idx + 12'd1;
        end
        if (eot) begin
            if (overflowed) begin
                v = V_OVERFLOW;
            end else if (byte_count < 12'd5) begin
                v = V_SHORT;
            end else if (!start_ok) begin
                v = V_BADSTART;
            end else if (size_field == 16'd0) begin
                v = (knock_field == {8'h2A, 8'h23}) ? V_KNOCK : V_EMPTY;
            end else if (int'(size_field) + 5 != int'(byte_count)) begin
                v = V_LENMISMATCH;
            end else if (crc_accum != 16'd0) begin
                v = V_CRC;
            end else if (knock_field[15:8] != seq_number) begin
                v = V_SEQ;
            end else begin
                v = V_OK;
            end
            res[n] = '{KIND_VERDICT, 8'h00, v, 1'b0};
            n++;
            if (v == V_OK) begin
                ack[0] = marker_reg;
                ack[1] = 8'h02;
                ack[2] = 8'h00;
                ack[3] = seq_number;
                ack[4] = ack_type_reg;
                c = 16'h0000;
                for (k = 1; k < 5; k++) begin
                    c = crc16_xmodem_next(c, ack[k]);
                end
                ack[5] = c[15:8];
                ack[6] = c[7:0];
                for (k = 0; k < 7; k++) begin
                    res[n] = '{KIND_ACK, ack[k], V_OK, 1'b0};
                    n++;
                end
                seq_number = seq_number + 8'd1;
            end
            clear_transaction();
        end
        if (n > 0) begin
            res[n - 1].run_end = 1'b1;
        end
        for (k = 0; k < n; k++) begin
            awaited_results.push_back(res[k]);
        end
    endtask

    task automatic check_result();
        t_result want;
        if (awaited_results.size() == 0) begin
            report_mismatch("result with nothing awaited",
                            int'({i_kind, i_out_byte, i_verdict, i_last_of_run}), 0);
        end else begin
            want = awaited_results.pop_front();
            if (i_kind !== want.kind) begin
                report_mismatch("kind", int'(i_kind), int'(want.kind));
            end
            if (i_out_byte !== want.out_byte) begin
                report_mismatch("out_byte", int'(i_out_byte), int'(want.out_byte));
            end
            if (i_verdict !== want.verdict) begin
                report_mismatch("verdict", int'(i_verdict), int'(want.verdict));
            end
            if (i_last_of_run !== want.run_end) begin
                report_mismatch("last_of_run", int'(i_last_of_run), int'(want.run_end));
            end
        end
    endtask

    initial begin
        fail_count   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            awaited_results.delete();
            marker_reg   = '0;
            ack_type_reg = '0;
            seq_number   = '0;
            clear_transaction();
        end else begin
            if (i_pop && !i_empty) begin
                check_result();
            end
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_START_MARKER) begin
                    marker_reg = i_cfg_wdata;
                end else begin
                    ack_type_reg = i_cfg_wdata;
                end
            end
            if (i_push && !i_full) begin
                absorb_byte(i_data_byte, i_end_of_transaction);
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fail_count;
    end

endmodule

>>> tb/sv/testbench.sv
// Testbench top: clock, reset, frame stimulus, result drain and final verdict.
`timescale 1ns / 1ps

module testbench;
    import fpr_pkg::*;
    import fpr_tb_pkg::*;

    localparam int MAX_BYTES   = 2048;
    localparam int CYCLE_LIMIT = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic       i_cfg_index = CFG_START_MARKER;
    logic [7:0] i_cfg_wdata = 8'h00;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_end_of_transaction = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [1:0] o_kind;
    logic [7:0] o_out_byte;
    logic [3:0] o_verdict;
    logic       o_last_of_run;

    int         fail_count;
    int         pending_count;
    int         cycle_count = 0;
    int         burst_left = 0;
    int         stall_left = 0;
    int         stall_mode = 0;
    logic [7:0] cfg_marker = 8'h00;
    logic [7:0] seq_shadow = 8'h00;
    logic [7:0] frame_q [$];

    always #5 i_clk = ~i_clk;

    framed_packet_receive_checker #(
        .MAX_TRANSACTION(MAX_BYTES)
    ) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .push                (push),
        .full                (full),
        .i_data_byte         (i_data_byte),
        .i_end_of_transaction(i_end_of_transaction),
        .empty               (empty),
        .pop                 (pop),
        .o_kind              (o_kind),
        .o_out_byte          (o_out_byte),
        .o_verdict           (o_verdict),
        .o_last_of_run       (o_last_of_run)
    );

    fpr_frame_monitor #(
        .MAX_BYTES(MAX_BYTES)
    ) monitor (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_push              (push),
        .i_full              (full),
        .i_data_byte         (i_data_byte),
        .i_end_of_transaction(i_end_of_transaction),
        .i_empty             (empty),
        .i_pop               (pop),
        .i_kind              (o_kind),
        .i_out_byte          (o_out_byte),
        .i_verdict           (o_verdict),
        .i_last_of_run       (o_last_of_run),
        .o_fail_count        (fail_count),
        .o_pending           (pending_count)
    );

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= ((stall_left % 8) < 5);
        endcase
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        push                 <= 1'b1;
        i_data_byte          <= b;
        i_end_of_transaction <= eot;
        do @(posedge i_clk); while (full);
        burst_left--;
    endtask

    task automatic send_frame();
        int k;
        for (k = 0; k < frame_q.size(); k++) begin
            send_byte(frame_q[k], k == frame_q.size() - 1);
        end
    endtask

    task automatic build_good(input logic [7:0] seq, input int len);
        logic [15:0] size;
        logic [15:0] crc;
        int          k;
        size = 16'(len + 2);
        frame_q.delete();
        frame_q.push_back(cfg_marker);
        frame_q.push_back(size[7:0]);
        frame_q.push_back(size[15:8]);
        frame_q.push_back(seq);
        frame_q.push_back(8'($urandom));
        for (k = 0; k < len; k++) begin
            frame_q.push_back(8'($urandom));
        end
        crc = 16'h0000;
        for (k = 1; k < frame_q.size(); k++) begin
            crc = crc16_xmodem_next(crc, frame_q[k]);
        end
        frame_q.push_back(crc[15:8]);
        frame_q.push_back(crc[7:0]);
    endtask

    task automatic build_random(input int count, input logic marker_first);
        int k;
        frame_q.delete();
        for (k = 0; k < count; k++) begin
            frame_q.push_back(8'($urandom));
        end
        if (marker_first) begin
            frame_q[0] = cfg_marker;
        end
    endtask

    task automatic build_zero_size(input logic knock);
        int k;
        int tail;
        frame_q.delete();
        frame_q.push_back(cfg_marker);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h00);
        frame_q.push_back(knock ? 8'h2A : 8'($urandom));
        frame_q.push_back(knock ? 8'h23 : 8'($urandom));
        tail = $urandom_range(0, 3);
        for (k = 0; k < tail; k++) begin
            frame_q.push_back(8'($urandom));
        end
    endtask

    task automatic random_transaction();
        int sel;
        int len;
        int pos;
        sel = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        if (sel < 45) begin
            build_good(seq_shadow, len);
            seq_shadow = seq_shadow + 8'd1;
        end else if (sel < 52) begin
            build_good(seq_shadow + 8'($urandom_range(1, 255)), len);
        end else if (sel < 60) begin
            build_good(seq_shadow, len);
            pos = $urandom_range(1, frame_q.size() - 1);
            frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(0, 7));
        end else if (sel < 66) begin
            build_good(seq_shadow, len);
            if ($urandom_range(0, 1) == 0) begin
                void'(frame_q.pop_back());
            end else begin
                frame_q.push_back(8'($urandom));
            end
        end else if (sel < 72) begin
            build_good(seq_shadow, len);
            frame_q[0] = frame_q[0] ^ 8'($urandom_range(1, 255));
        end else if (sel < 78) begin
            build_zero_size(1'b1);
        end else if (sel < 84) begin
            build_zero_size(1'b0);
        end else if (sel < 92) begin
            build_random($urandom_range(1, 4), $urandom_range(0, 1) == 1);
        end else begin
            build_random($urandom_range(1, 24), $urandom_range(0, 1) == 1);
        end
        send_frame();
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] marker, input logic [7:0] ack_type);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_START_MARKER;
        i_cfg_wdata <= marker;
        @(posedge i_clk);
        i_cfg_index <= CFG_ACK_TYPE;
        i_cfg_wdata <= ack_type;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_marker = marker;
    endtask

    initial begin
        int phase;
        int items;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_config(8'hA5, 8'h3C);

        // directed transactions: single byte, knock, empty frame, good frame, repeated sequence number
        frame_q = '{8'hFF};
        send_frame();
        build_zero_size(1'b1);
        send_frame();
        frame_q = '{cfg_marker, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame();
        build_good(seq_shadow, 0);
        send_frame();
        build_good(seq_shadow, 1);
        send_frame();
        seq_shadow = seq_shadow + 8'd1;

        for (phase = 0; phase < 4; phase++) begin
            drain_results();
            case (phase)
                0: write_config(8'h00, 8'hFF);
                1: write_config(8'hFF, 8'h00);
                default: write_config(8'($urandom), 8'($urandom));
            endcase
            items = 0;
            while (items < 16) begin
                random_transaction();
                items += frame_q.size();
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("PASS framed_packet_receive_checker");
        end else begin
            $display("FAIL framed_packet_receive_checker");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL framed_packet_receive_checker");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/fpr_pkg.sv
hw/rtl/fpr_front.sv
hw/rtl/fpr_cmd_fifo.sv
hw/rtl/fpr_back.sv
hw/rtl/framed_packet_receive_checker.sv
tb/sv/fpr_tb_pkg.sv
tb/sv/fpr_frame_monitor.sv
tb/sv/testbench.sv
